>>> rtl/pkmob_pkg.sv
// ----------------------------------------------------------------------------
// pkmob_pkg
// Shared types and status codes for the per-key minimum price order book.
// ----------------------------------------------------------------------------
package pkmob_pkg;

    typedef struct packed {
        logic        mode;
        logic [31:0] stock_id;
        logic [31:0] price;
    } pkmob_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] sold_price;
    } pkmob_out_t;

    localparam logic [2:0] ST_ADDED    = 3'd0;
    localparam logic [2:0] ST_SOLD     = 3'd1;
    localparam logic [2:0] ST_NONE     = 3'd2;
    localparam logic [2:0] ST_HALT     = 3'd3;
    localparam logic [2:0] ST_IDFULL   = 3'd4;
    localparam logic [2:0] ST_HEAPFULL = 3'd5;

    localparam logic MODE_ADD = 1'b0;
    localparam logic MODE_BUY = 1'b1;

endpackage

>>> rtl/pkmob_ram.sv
// ----------------------------------------------------------------------------
// pkmob_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module pkmob_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> rtl/per_key_min_price_order_book.sv
// ----------------------------------------------------------------------------
// per_key_min_price_order_book
// One min-heap of (price, units) per stock id, held in a single RAM.
// ----------------------------------------------------------------------------
// channel | direction | payload     | handshake
// in      | into      | pkmob_in_t  | in_valid / in_stall
// out     | out of    | pkmob_out_t | out_valid / out_stall
// cfg     | into      | max_id      | cfg_we / cfg_wdata
//
// One request at a time. Id lookup scans the known ids in turn, the equal
// price search reads the heap entries in turn, and a sift walks the heap
// level by level over the single RAM port.
// Reset clears the id count, heap sizes and halt flag; RAM contents are
// only read below the heap size. A result waits in the output register while
// the next request is already taken.
// ----------------------------------------------------------------------------
module per_key_min_price_order_book #(
    parameter int MAX_STOCKS = 16,
    parameter int HEAP_DEPTH = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [31:0]           cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  pkmob_pkg::pkmob_in_t  in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output pkmob_pkg::pkmob_out_t out_data
);
    import pkmob_pkg::*;

    localparam int SW = (MAX_STOCKS > 1) ? $clog2(MAX_STOCKS) : 1;
    localparam int HW = $clog2(HEAP_DEPTH);
    localparam int AW = SW + HW;
    localparam int DEPTH = (1 << SW) * (1 << HW);
    localparam int CW = $clog2(MAX_STOCKS + 1);
    localparam int NW = $clog2(HEAP_DEPTH + 1);

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_ID    = 14'b00000000000010,
        S_SRD   = 14'b00000000000100,
        S_SCHK  = 14'b00000000001000,
        S_UPRD  = 14'b00000000010000,
        S_UPCHK = 14'b00000000100000,
        S_ROOT  = 14'b00000001000000,
        S_LAST  = 14'b00000010000000,
        S_DNL   = 14'b00000100000000,
        S_DNLC  = 14'b00001000000000,
        S_DNRC  = 14'b00010000000000,
        S_WA    = 14'b00100000000000,
        S_WB    = 14'b01000000000000,
        S_DONE  = 14'b10000000000000
    } state_t;

    state_t state_reg;

    logic [31:0] max_id_reg;
    logic [31:0] id_tags_reg [MAX_STOCKS];
    logic [CW-1:0] id_count_reg;
    logic [NW-1:0] heap_size_reg [MAX_STOCKS];
    logic halted_reg;

    pkmob_in_t req_reg;
    logic [CW-1:0] scan_reg;
    logic [SW-1:0] slot_reg;
    logic [NW-1:0] k_reg, size_reg;
    logic [HW-1:0] i_reg, j_reg;
    logic [31:0] cp_reg, cu_reg, mp_reg, mu_reg;
    logic [HW-1:0] m_reg;
    logic [HW-1:0] wa_reg, wb_reg;
    logic [63:0] wad_reg, wbd_reg;
    logic [2:0] res_reg;
    logic [31:0] sold_reg;
    logic out_valid_reg;
    pkmob_out_t out_reg;
    logic from_last_reg;

    logic ram_we;
    logic [HW-1:0] ram_idx;
    logic [63:0] ram_wdata, ram_rdata;
    logic [31:0] rd_p, rd_u;

    assign rd_p = ram_rdata[63:32];
    assign rd_u = ram_rdata[31:0];

    pkmob_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_heap (
        .clk  (clk),
        .we   (ram_we),
        .addr ({slot_reg, ram_idx}),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    logic accept;
    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // children of i, widened one bit past count width for bounds tests
    logic [NW:0] lc, rc;
    assign lc = (NW+1)'({i_reg, 1'b1});
    assign rc = (NW+1)'({i_reg, 1'b0}) + (NW+1)'(2);

    always_comb
    begin
        ram_we = 1'b0;
        ram_idx = k_reg[HW-1:0];
        ram_wdata = '0;
        unique case (state_reg)
            S_IDLE:  ;
            S_ID:    ;
            S_SRD:   ram_idx = k_reg[HW-1:0];
            S_SCHK:  ;
            S_UPRD:  ram_idx = j_reg;
            S_UPCHK: ;
            S_ROOT:  ram_idx = '0;
            S_LAST:  ram_idx = HW'(size_reg - 1'b1);
            S_DNL:   ram_idx = lc[HW-1:0];
            S_DNLC:  ram_idx = rc[HW-1:0];
            S_DNRC:  ;
            S_WA:
            begin
                ram_we = 1'b1;
                ram_idx = wa_reg;
                ram_wdata = wad_reg;
            end
            S_WB:
            begin
                ram_we = 1'b1;
                ram_idx = wb_reg;
                ram_wdata = wbd_reg;
            end
            S_DONE:  ;
            default: ;
        endcase
    end

    // after-write continuation code
    typedef enum logic [2:0] {
        C_DONE = 3'b001,
        C_UP   = 3'b010,
        C_DOWN = 3'b100
    } cont_t;
    cont_t cont_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            max_id_reg    <= 32'hFFFF_FFFF;
            id_count_reg  <= '0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            cont_reg      <= C_DONE;
            for (int s = 0; s < MAX_STOCKS; s++)
            begin
                heap_size_reg[s] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                max_id_reg <= cfg_wdata;
            end
            if (out_valid_reg && !out_stall && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        req_reg  <= in_data;
                        scan_reg <= '0;
                        sold_reg <= '0;
                        if (halted_reg || in_data.stock_id > max_id_reg
                            || in_data.price == '0)
                        begin
                            halted_reg <= 1'b1;
                            res_reg    <= ST_HALT;
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_ID;
                        end
                    end
                end
                S_ID:
                begin
                    if (scan_reg == id_count_reg)
                    begin
                        if (req_reg.mode != MODE_ADD)
                        begin
                            res_reg   <= ST_NONE;
                            state_reg <= S_DONE;
                        end
                        else if (id_count_reg == CW'(MAX_STOCKS))
                        begin
                            res_reg   <= ST_IDFULL;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            slot_reg <= scan_reg[SW-1:0];
                            id_tags_reg[scan_reg[SW-1:0]] <= req_reg.stock_id;
                            id_count_reg <= id_count_reg + 1'b1;
                            heap_size_reg[scan_reg[SW-1:0]] <= NW'(1);
                            wa_reg   <= '0;
                            wad_reg  <= {req_reg.price, 32'd1};
                            wb_reg   <= '0;
                            wbd_reg  <= {req_reg.price, 32'd1};
                            cont_reg <= C_DONE;
                            res_reg  <= ST_ADDED;
                            state_reg <= S_WA;
                        end
                    end
                    else if (id_tags_reg[scan_reg[SW-1:0]] == req_reg.stock_id)
                    begin
                        slot_reg <= scan_reg[SW-1:0];
                        size_reg <= heap_size_reg[scan_reg[SW-1:0]];
                        k_reg    <= '0;
                        if (req_reg.mode == MODE_ADD)
                        begin
                            state_reg <= S_SRD;
                        end
                        else if (heap_size_reg[scan_reg[SW-1:0]] == '0)
                        begin
                            res_reg   <= ST_NONE;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_ROOT;
                        end
                    end
                    else
                    begin
                        scan_reg <= scan_reg + 1'b1;
                    end
                end
                S_SRD:
                begin
                    if (k_reg == size_reg)
                    begin
                        if (size_reg == NW'(HEAP_DEPTH))
                        begin
                            res_reg   <= ST_HEAPFULL;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            heap_size_reg[slot_reg] <= size_reg + 1'b1;
                            i_reg  <= size_reg[HW-1:0];
                            cp_reg <= req_reg.price;
                            cu_reg <= 32'd1;
                            wa_reg <= size_reg[HW-1:0];
                            wad_reg <= {req_reg.price, 32'd1};
                            wb_reg <= size_reg[HW-1:0];
                            wbd_reg <= {req_reg.price, 32'd1};
                            res_reg  <= ST_ADDED;
                            cont_reg <= C_UP;
                            state_reg <= S_WA;
                        end
                    end
                    else
                    begin
                        state_reg <= S_SCHK;
                    end
                end
                S_SCHK:
                begin
                    if (rd_p == req_reg.price)
                    begin
                        wa_reg  <= k_reg[HW-1:0];
                        wb_reg  <= k_reg[HW-1:0];
                        wad_reg <= {rd_p, (rd_u == '1) ? rd_u : rd_u + 32'd1};
                        wbd_reg <= {rd_p, (rd_u == '1) ? rd_u : rd_u + 32'd1};
                        res_reg <= ST_ADDED;
                        cont_reg <= C_DONE;
                        state_reg <= S_WA;
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                        state_reg <= S_SRD;
                    end
                end
                S_UPRD:
                begin
                    state_reg <= S_UPCHK;
                end
                S_UPCHK:
                begin
                    // parent at j_reg; current entry (cp,cu) at i_reg
                    if (rd_p <= cp_reg)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        wa_reg  <= i_reg;
                        wad_reg <= ram_rdata;
                        wb_reg  <= j_reg;
                        wbd_reg <= {cp_reg, cu_reg};
                        i_reg   <= j_reg;
                        state_reg <= S_WA;
                    end
                end
                S_ROOT:
                begin
                    state_reg <= S_LAST;
                end
                S_LAST:
                begin
                    // root data arrives now
                    if (rd_p > req_reg.price)
                    begin
                        res_reg   <= ST_NONE;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        res_reg  <= ST_SOLD;
                        sold_reg <= rd_p;
                        if (rd_u > 32'd1)
                        begin
                            wa_reg  <= '0;
                            wb_reg  <= '0;
                            wad_reg <= {rd_p, rd_u - 32'd1};
                            wbd_reg <= {rd_p, rd_u - 32'd1};
                            cont_reg <= C_DONE;
                            state_reg <= S_WA;
                        end
                        else
                        begin
                            size_reg <= size_reg - 1'b1;
                            heap_size_reg[slot_reg] <= size_reg - 1'b1;
                            i_reg <= '0;
                            state_reg <= S_DNL;
                        end
                    end
                end
                S_DNL:
                begin
                    // last entry (index size_reg after decrement) read in S_LAST
                    if (from_last_reg)
                    begin
                        cp_reg <= rd_p;
                        cu_reg <= rd_u;
                    end
                    if (size_reg == '0)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_DNLC;
                    end
                end
                S_DNLC:
                begin
                    // left child data arrives now (read in S_DNL)
                    if (lc < (NW+1)'(size_reg) && rd_p < cp_reg)
                    begin
                        mp_reg <= rd_p;
                        mu_reg <= rd_u;
                        m_reg  <= lc[HW-1:0];
                    end
                    else
                    begin
                        mp_reg <= cp_reg;
                        mu_reg <= cu_reg;
                        m_reg  <= i_reg;
                    end
                    state_reg <= S_DNRC;
                end
                S_DNRC:
                begin
                    if (rc < (NW+1)'(size_reg) && rd_p < mp_reg)
                    begin
                        wa_reg  <= i_reg;
                        wad_reg <= ram_rdata;
                        wb_reg  <= rc[HW-1:0];
                        wbd_reg <= {cp_reg, cu_reg};
                        i_reg   <= rc[HW-1:0];
                        cont_reg <= C_DOWN;
                        state_reg <= S_WA;
                    end
                    else if (m_reg != i_reg)
                    begin
                        wa_reg  <= i_reg;
                        wad_reg <= {mp_reg, mu_reg};
                        wb_reg  <= m_reg;
                        wbd_reg <= {cp_reg, cu_reg};
                        i_reg   <= m_reg;
                        cont_reg <= C_DOWN;
                        state_reg <= S_WA;
                    end
                    else
                    begin
                        wa_reg  <= i_reg;
                        wb_reg  <= i_reg;
                        wad_reg <= {cp_reg, cu_reg};
                        wbd_reg <= {cp_reg, cu_reg};
                        cont_reg <= C_DONE;
                        state_reg <= S_WA;
                    end
                end
                S_WA:
                begin
                    state_reg <= S_WB;
                end
                S_WB:
                begin
                    unique case (cont_reg)
                        C_UP:
                        begin
                            if (i_reg != '0)
                            begin
                                j_reg <= HW'((i_reg - 1'b1) >> 1);
                                state_reg <= S_UPRD;
                            end
                            else
                            begin
                                state_reg <= S_DONE;
                            end
                        end
                        C_DOWN:  state_reg <= S_DNL;
                        C_DONE:  state_reg <= S_DONE;
                        default: state_reg <= S_DONE;
                    endcase
                end
                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_reg.status     <= res_reg;
                        out_reg.sold_price <= (res_reg == ST_SOLD) ? sold_reg : '0;
                        out_valid_reg      <= 1'b1;
                        state_reg          <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // In S_DNL the carried entry is only fresh on the first level; later levels
    // keep (cp,cu) moving down, so refresh only when coming from S_LAST.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            from_last_reg <= 1'b0;
        end
        else
        begin
            from_last_reg <= (state_reg == S_LAST);
        end
    end

    ap_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        id_count_reg <= CW'(MAX_STOCKS))
        else $error("id count overflow");
    ap_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE)
        else $error("request accepted without work");
    ap_halt: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt cleared");
    ap_out: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg)
        else $error("result lost");

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Request/result check of the per-key minimum price order book: a local
// model of the per-id heaps predicts each status and sold price; directed
// tests cover the limits, random tests run add/buy traffic under idling.
// ----------------------------------------------------------------------------
module tb_top;
    import pkmob_pkg::*;

    localparam int NSTK  = 16;
    localparam int DEPTH = 64;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    pkmob_in_t   in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    pkmob_out_t  out_data;

    per_key_min_price_order_book dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // book model
    logic [31:0] bk_max_id;
    logic [31:0] bk_tag [NSTK];
    int          bk_ids;
    logic [31:0] bk_price [NSTK][DEPTH];
    logic [31:0] bk_units [NSTK][DEPTH];
    int          bk_size [NSTK];
    logic        bk_halted;

    pkmob_out_t  pending_results[$];
    int          mismatches = 0;
    int          n_sent = 0;

    function automatic void book_clear();
        bk_max_id = '1;
        bk_ids    = 0;
        bk_halted = 1'b0;
        foreach (bk_size[s]) bk_size[s] = 0;
    endfunction

    function automatic int slot_of(logic [31:0] id);
        for (int s = 0; s < bk_ids; s++)
            if (bk_tag[s] == id) return s;
        return -1;
    endfunction

    function automatic void swap_ent(int s, int a, int b);
        logic [31:0] p, u;
        p = bk_price[s][a]; u = bk_units[s][a];
        bk_price[s][a] = bk_price[s][b]; bk_units[s][a] = bk_units[s][b];
        bk_price[s][b] = p; bk_units[s][b] = u;
    endfunction

    function automatic pkmob_out_t book_apply(pkmob_in_t r);
        pkmob_out_t res;
        int s, n, i, l, m, k;
        res = '0;
        if (!bk_halted && (r.stock_id > bk_max_id || r.price == 0)) bk_halted = 1'b1;
        if (bk_halted)
        begin
            res.status = ST_HALT;
            return res;
        end
        s = slot_of(r.stock_id);
        if (r.mode == MODE_ADD)
        begin
            res.status = ST_ADDED;
            if (s < 0)
            begin
                if (bk_ids >= NSTK)
                begin
                    res.status = ST_IDFULL;
                    return res;
                end
                bk_tag[bk_ids] = r.stock_id;
                bk_price[bk_ids][0] = r.price;
                bk_units[bk_ids][0] = 1;
                bk_size[bk_ids] = 1;
                bk_ids++;
                return res;
            end
            n = bk_size[s];
            for (k = 0; k < n; k++)
                if (bk_price[s][k] == r.price)
                begin
                    if (bk_units[s][k] != '1) bk_units[s][k]++;
                    return res;
                end
            if (n >= DEPTH)
            begin
                res.status = ST_HEAPFULL;
                return res;
            end
            bk_price[s][n] = r.price;
            bk_units[s][n] = 1;
            bk_size[s] = n + 1;
            i = n;
            while (i > 0 && bk_price[s][(i-1)/2] > bk_price[s][i])
            begin
                swap_ent(s, i, (i-1)/2);
                i = (i-1)/2;
            end
            return res;
        end
        res.status = ST_NONE;
        if (s < 0 || bk_size[s] == 0 || bk_price[s][0] > r.price) return res;
        res.status = ST_SOLD;
        res.sold_price = bk_price[s][0];
        if (bk_units[s][0] > 0) bk_units[s][0]--;
        if (bk_units[s][0] == 0)
        begin
            n = bk_size[s] - 1;
            bk_price[s][0] = bk_price[s][n];
            bk_units[s][0] = bk_units[s][n];
            bk_size[s] = n;
            i = 0;
            forever
            begin
                l = 2*i + 1; m = i;
                if (l < n && bk_price[s][l] < bk_price[s][m]) m = l;
                if (l + 1 < n && bk_price[s][l+1] < bk_price[s][m]) m = l + 1;
                if (m == i) break;
                swap_ent(s, i, m);
                i = m;
            end
        end
        return res;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        pkmob_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", out_data);
            end
            else
            begin
                want = pending_results.pop_front();
                if (want.status !== out_data.status || want.sold_price !== out_data.sold_price)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp st=%0d px=%0d got st=%0d px=%0d",
                                 want.status, want.sold_price,
                                 out_data.status, out_data.sold_price);
                end
            end
        end
    end

    // receiver stall, redrawn per result
    initial
    begin
        int w;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            w = (n_sent % 300 < 60) ? 0 : $urandom_range(0, 4);
            if (w != 0)
            begin
                out_stall <= 1'b1;
                repeat (w) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    task automatic send_req(logic mode, logic [31:0] id, logic [31:0] price);
        pkmob_in_t r;
        int gap;
        r.mode = mode; r.stock_id = id; r.price = price;
        gap = (n_sent % 300 < 60) ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data  <= r;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        pending_results.push_back(book_apply(r));
        n_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (2*DEPTH + NSTK + 60) @(negedge clk);
    endtask

    task automatic set_max_id(logic [31:0] v);
        drain();
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
        bk_max_id = v;
    endtask

    task automatic do_reset();
        // only at start
        rst_n = 1'b0;
        book_clear();
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
    endtask

    task automatic test_limits();
        send_req(MODE_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_req(MODE_ADD, 32'hFFFF_FFFF, 32'd1);
        send_req(MODE_ADD, 32'hFFFF_FFFF, 32'd1);
        send_req(MODE_BUY, 32'hFFFF_FFFF, 32'd0 + 32'd1);
        send_req(MODE_BUY, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_req(MODE_BUY, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_req(MODE_BUY, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_req(MODE_BUY, 32'd0, 32'd5);
        for (int i = 0; i < 16; i++) send_req(MODE_ADD, 32'(i), 32'd100 + 32'(i));
        send_req(MODE_ADD, 32'd77, 32'd3);
        send_req(MODE_BUY, 32'd77, 32'd3);
    endtask

    task automatic test_heap_full();
        for (int p = DEPTH + 1; p >= 1; p--) send_req(MODE_ADD, 32'd5, 32'(p * 7));
        for (int i = 0; i < 10; i++) send_req(MODE_BUY, 32'd5, 32'($urandom_range(1, 500)));
    endtask

    // halting is permanent; run last
    task automatic test_halt();
        set_max_id(32'd0);
        send_req(MODE_ADD, 32'd0, 32'd9);
        send_req(MODE_BUY, 32'd0, 32'd9);
        set_max_id(32'd20);
        send_req(MODE_ADD, 32'd20, 32'd4);
        send_req(MODE_BUY, 32'd20, 32'd0);
        send_req(MODE_ADD, 32'd1, 32'd4);
        send_req(MODE_BUY, 32'd21, 32'd4);
    endtask

    task automatic test_random(int count);
        logic [31:0] id, px;
        for (int i = 0; i < count; i++)
        begin
            id = (($urandom_range(0, 40) == 0) ? $urandom : $urandom_range(0, 19));
            if ($urandom_range(0, 3) == 0) id = 32'hFFFF_FFF0 + $urandom_range(0, 15);
            case ($urandom_range(0, 2))
                0: px = $urandom_range(1, 40);
                1: px = $urandom | 32'd1;
                default: px = {2'($urandom_range(1, 3)), 30'h3FFF_FFF0}
                              + 32'($urandom_range(0, 15));
            endcase
            send_req(1'($urandom_range(0, 1)), id, px);
        end
    endtask

    initial
    begin
        do_reset();
        test_limits();
        test_heap_full();
        set_max_id(32'hFFFF_FFFF);
        test_random(1300);
        test_halt();
        drain();
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
